// ===== hw/rtl/cdac_pkg.sv =====
// Shared types, constants and helpers for the DAC calibration and note block.
// No dependencies; cdac_table, cdac_seq, the top and the testbench import it.
package cdac_pkg;

  localparam int unsigned TBL_W           = 16;
  localparam int unsigned CODE_W          = 12;
  localparam int unsigned MEASURED_POINTS = 9;
  localparam int unsigned EXTRAP_SHIFT    = 3;
  localparam int unsigned SEMIS_PER_SEG   = 6;
  localparam int unsigned MAX_NOTE        = 83;

  localparam logic [TBL_W-1:0] CODE_LIMIT = 16'd4096;
  // note / 6 for notes up to MAX_NOTE: (note * 43) >> 8
  localparam logic [5:0]       SEG_MUL    = 6'd43;
  // x / 6 for 16-bit x: (x * 43691) >> 18
  localparam logic [15:0]      DIV6_MUL   = 16'd43691;
  localparam int unsigned      DIV6_SHIFT = 18;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_NOTE   = 2'd2
  } action_e;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [1:0] REF_CHAN [4] = '{2'd3, 2'd3, 2'd3, 2'd0};
  localparam logic [CODE_W-1:0] REF_CODE [MEASURED_POINTS] = '{
    12'd0, 12'd500, 12'd1000, 12'd1500, 12'd2000, 12'd2500, 12'd3000, 12'd3500, 12'd4000
  };

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] channel;
    logic [6:0] note;
    logic       comparator_high;
  } cdac_req_t;

  typedef struct packed {
    logic        kind;
    logic        chip_select;
    logic [15:0] dac_word;
    logic        last;
  } cdac_rsp_t;

  // bit15: odd channel, bit12: active, low 12 bits: code
  function automatic logic [15:0] make_word(input logic [1:0] ch, input logic [CODE_W-1:0] code);
    return {ch[0], 3'b001, code};
  endfunction

endpackage

// ===== hw/rtl/cdac_stream_if.sv =====
// Valid/ready request channel with a typed payload.
// Payload types come from cdac_pkg at the point of instantiation.
interface cdac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cdac_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdac_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 60,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cdac_table.sv =====
// Calibration table: cdac_ram plus per-entry valid bits so the table reads
// as zero after reset. Depends on cdac_pkg and cdac_ram.
module cdac_table
  import cdac_pkg::*;
#(
  parameter int unsigned DEPTH = 60,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [TBL_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [TBL_W-1:0] rdata_o
);

  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;
  logic [TBL_W-1:0] ram_rdata;

  cdac_ram #(
    .WIDTH (TBL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : '0;

endmodule

// ===== hw/rtl/cdac_seq.sv =====
// Sequencer: decodes requests, runs table read-modify-write, extrapolation
// and note interpolation, and holds the output register. Depends on cdac_pkg and cdac_stream_if.
module cdac_seq
  import cdac_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned TABLE_POINTS = 15,
  localparam int unsigned TBL_AW      = $clog2(NUM_CHANNELS * TABLE_POINTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdac_stream_if.sink       in_i,
  cdac_stream_if.source     out_o,
  output logic              tbl_we_o,
  output logic [TBL_AW-1:0] tbl_waddr_o,
  output logic [TBL_W-1:0]  tbl_wdata_o,
  output logic              tbl_re_o,
  output logic [TBL_AW-1:0] tbl_raddr_o,
  input  logic [TBL_W-1:0]  tbl_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO_ALL, S_BEGIN, S_POINT_CH, S_INC_RD, S_WR_EMIT, S_EXT_RD0,
    S_EXT_RD1, S_EXT_WR, S_DONE, S_NOTE_RD0, S_NOTE_RD1, S_NOTE_DIV, S_NOTE_MUL
  } state_e;

  function automatic logic chan_ok(input logic [1:0] ch);
    return {1'b0, ch} < 3'(NUM_CHANNELS);
  endfunction

  function automatic logic [TBL_AW-1:0] addr_of(input logic [1:0] ch, input logic [3:0] idx);
    return TBL_AW'(ch) * TBL_AW'(TABLE_POINTS) + TBL_AW'(idx);
  endfunction

  state_e           state_q, state_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       ch_q, ch_d;
  logic [1:0]       cal_ch_q, cal_ch_d;
  logic             calibrating_q, calibrating_d;
  logic [3:0]       pt_q, pt_d;
  logic [3:0]       idx_q, idx_d;
  logic [2:0]       k_q, k_d;
  logic [TBL_W-1:0] val_q, val_d;
  logic [TBL_W-1:0] step_q, step_d;
  logic [15:0]      mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [13:0]      quot_q, quot_d;
  logic             out_valid_q, out_valid_d;
  cdac_rsp_t        out_data_q, out_data_d;

  cdac_req_t         req;
  logic [12:0]       note_prod;
  logic [3:0]        note_seg;
  logic [2:0]        note_k;
  logic              note_ok;
  logic [16:0]       note_diff;
  logic [31:0]       div_prod;
  logic [TBL_W-1:0]  note_size;
  logic [TBL_W-1:0]  note_code;
  logic [TBL_W-1:0]  inc_val;
  logic [TBL_W-1:0]  ext_val;
  logic [1:0]        ref_ch;

  logic              slot_free;
  logic              emit_req;
  logic              emit_fire;
  logic              emit_done;
  logic              emit_last;
  logic [1:0]        emit_ch;
  logic [CODE_W-1:0] emit_code;
  cdac_rsp_t         emit_rsp;

  assign req       = in_i.payload;
  assign note_prod = 13'(req.note) * 13'(SEG_MUL);
  assign note_seg  = note_prod[11:8];
  assign note_k    = 3'(req.note - 7'(note_seg) * 7'(SEMIS_PER_SEG));
  assign note_ok   = chan_ok(req.channel) && (req.note <= 7'(MAX_NOTE))
                     && (5'(note_seg) + 5'd1 < 5'(TABLE_POINTS));

  assign note_diff = {1'b0, tbl_rdata_i} - {1'b0, val_q};
  assign div_prod  = 32'(mag_q) * 32'(DIV6_MUL);
  assign note_size = neg_q ? (16'd0 - {2'b00, quot_q}) : {2'b00, quot_q};
  assign note_code = val_q + 16'(note_size * 16'(k_q));
  assign inc_val   = tbl_rdata_i + 16'd1;
  assign ext_val   = val_q + step_q;
  assign ref_ch    = REF_CHAN[ch_q];

  assign slot_free = !out_valid_q || out_o.ready;
  assign emit_fire = emit_req && slot_free;

  always_comb begin
    emit_rsp.kind        = emit_done ? KIND_DONE : KIND_WRITE;
    emit_rsp.chip_select = emit_done ? 1'b0 : emit_ch[1];
    emit_rsp.dac_word    = emit_done ? 16'd0 : make_word(emit_ch, emit_code);
    emit_rsp.last        = emit_last;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ch_d          = ch_q;
    cal_ch_d      = cal_ch_q;
    calibrating_d = calibrating_q;
    pt_d          = pt_q;
    idx_d         = idx_q;
    k_d           = k_q;
    val_d         = val_q;
    step_d        = step_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    quot_d        = quot_q;
    tbl_we_o      = 1'b0;
    tbl_waddr_o   = '0;
    tbl_wdata_o   = '0;
    tbl_re_o      = 1'b0;
    tbl_raddr_o   = '0;
    emit_req      = 1'b0;
    emit_done     = 1'b0;
    emit_last     = 1'b0;
    emit_ch       = ch_q;
    emit_code     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (req.action)
            ACT_START: begin
              if (chan_ok(req.channel)) begin
                ch_d          = req.channel;
                cal_ch_d      = req.channel;
                calibrating_d = 1'b1;
                pt_d          = '0;
                cnt_d         = '0;
                state_d       = S_ZERO_ALL;
              end
            end
            ACT_SAMPLE: begin
              if (calibrating_q) begin
                ch_d = cal_ch_q;
                if (!req.comparator_high) begin
                  tbl_re_o    = 1'b1;
                  tbl_raddr_o = addr_of(cal_ch_q, pt_q);
                  state_d     = S_INC_RD;
                end else if (pt_q < 4'(MEASURED_POINTS - 1)) begin
                  pt_d    = pt_q + 4'd1;
                  state_d = S_BEGIN;
                end else begin
                  tbl_re_o      = 1'b1;
                  tbl_raddr_o   = addr_of(cal_ch_q, 4'(MEASURED_POINTS - 1));
                  calibrating_d = 1'b0;
                  pt_d          = '0;
                  state_d       = S_EXT_RD0;
                end
              end
            end
            ACT_NOTE: begin
              if (note_ok) begin
                ch_d        = req.channel;
                idx_d       = note_seg;
                k_d         = note_k;
                tbl_re_o    = 1'b1;
                tbl_raddr_o = addr_of(req.channel, note_seg);
                state_d     = S_NOTE_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      S_ZERO_ALL: begin
        emit_req = 1'b1;
        emit_ch  = cnt_q;
        if (emit_fire) begin
          if (cnt_q == 2'(NUM_CHANNELS - 1)) begin
            state_d = S_BEGIN;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      S_BEGIN: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = addr_of(ch_q, pt_q);
        if (chan_ok(ref_ch)) begin
          emit_req  = 1'b1;
          emit_ch   = ref_ch;
          emit_code = REF_CODE[pt_q];
          if (emit_fire) begin
            state_d = S_POINT_CH;
          end
        end else begin
          state_d = S_POINT_CH;
        end
      end
      S_POINT_CH: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      S_INC_RD: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = addr_of(ch_q, pt_q);
        tbl_wdata_o = inc_val;
        val_d       = inc_val;
        state_d     = S_WR_EMIT;
      end
      S_WR_EMIT: begin
        if (val_q < CODE_LIMIT) begin
          emit_req  = 1'b1;
          emit_last = 1'b1;
          emit_code = val_q[CODE_W-1:0];
          if (emit_fire) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EXT_RD0: begin
        val_d       = tbl_rdata_i;
        tbl_re_o    = 1'b1;
        tbl_raddr_o = addr_of(ch_q, 4'd0);
        state_d     = S_EXT_RD1;
      end
      S_EXT_RD1: begin
        step_d  = (val_q - tbl_rdata_i) >> EXTRAP_SHIFT;
        idx_d   = 4'(MEASURED_POINTS);
        state_d = S_EXT_WR;
      end
      S_EXT_WR: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = addr_of(ch_q, idx_q);
        tbl_wdata_o = ext_val;
        val_d       = ext_val;
        if (idx_q == 4'(TABLE_POINTS - 1)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      S_DONE: begin
        emit_req  = 1'b1;
        emit_done = 1'b1;
        emit_last = 1'b1;
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      S_NOTE_RD0: begin
        val_d       = tbl_rdata_i;
        tbl_re_o    = 1'b1;
        tbl_raddr_o = addr_of(ch_q, idx_q + 4'd1);
        state_d     = S_NOTE_RD1;
      end
      S_NOTE_RD1: begin
        neg_d   = note_diff[16];
        mag_d   = note_diff[16] ? 16'(17'd0 - note_diff) : note_diff[15:0];
        state_d = S_NOTE_DIV;
      end
      S_NOTE_DIV: begin
        quot_d  = div_prod[31:DIV6_SHIFT];
        state_d = S_NOTE_MUL;
      end
      S_NOTE_MUL: begin
        val_d   = note_code;
        state_d = S_WR_EMIT;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit_fire ? 1'b1 : (out_valid_q && !out_o.ready);
    out_data_d  = emit_fire ? emit_rsp : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      ch_q          <= '0;
      cal_ch_q      <= '0;
      calibrating_q <= 1'b0;
      pt_q          <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      val_q         <= '0;
      step_q        <= '0;
      mag_q         <= '0;
      neg_q         <= 1'b0;
      quot_q        <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      ch_q          <= ch_d;
      cal_ch_q      <= cal_ch_d;
      calibrating_q <= calibrating_d;
      pt_q          <= pt_d;
      idx_q         <= idx_d;
      k_q           <= k_d;
      val_q         <= val_d;
      step_q        <= step_d;
      mag_q         <= mag_d;
      neg_q         <= neg_d;
      quot_q        <= quot_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

// ===== hw/rtl/cv_dac_calibrate_and_note.sv =====
// Ramp calibration and note output for a two-chip, four-channel 12-bit DAC.
// Requests are start, comparator sample and note; each may produce up to six
// results (DAC write commands or a calibration-done marker, last on the final
// one). One request is worked on at a time and the next is taken as soon as
// the sequencer is back in idle, even while the last result still sits in the
// output register. All table accesses share one memory read port and one
// write port with registered read data. A low sample reads, increments and
// writes back its entry; a note reads two entries, divides their difference
// by six and scales it; a start or a point change zeroes the point's entry;
// the final high sample reads two entries and writes the extrapolated ones.
// Each result waits until the output register is free. The table reads as
// zero after reset through per-entry valid bits, so no clearing pass runs.
// Depends on cdac_pkg, cdac_stream_if, cdac_seq and cdac_table.
module cv_dac_calibrate_and_note
  import cdac_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned TABLE_POINTS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cdac_stream_if.sink   in_i,
  cdac_stream_if.source out_o
);

  localparam int unsigned TBL_DEPTH = NUM_CHANNELS * TABLE_POINTS;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_W-1:0]  tbl_wdata;
  logic              tbl_re;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [TBL_W-1:0]  tbl_rdata;

  cdac_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TABLE_POINTS (TABLE_POINTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_re_o    (tbl_re),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata)
  );

  cdac_table #(
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

`ifndef SYNTHESIS
  // read-modify-write never overlaps a read of the entry being written
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we && tbl_re |-> tbl_waddr != tbl_raddr)
    else $error("table read and write hit the same entry");

  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !tbl_we)
    else $error("table written while a new request is accepted");

  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.kind == KIND_DONE |->
      out_o.payload.last && !out_o.payload.chip_select && out_o.payload.dac_word == 16'd0)
    else $error("malformed calibration-done result");

  a_write_active_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.kind == KIND_WRITE |-> out_o.payload.dac_word[12])
    else $error("DAC write without active bit");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for cv_dac_calibrate_and_note: predicts DAC writes and
// done markers per request, drives both streams with random idling and backpressure.
// Depends on cdac_pkg, cdac_stream_if and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import cdac_pkg::*;

  localparam int unsigned NCH      = 4;
  localparam int unsigned NPTS     = 15;
  localparam int unsigned MEAS     = 9;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  class dac_cmd_scoreboard;
    logic [15:0] cal_tbl [NCH*NPTS];
    bit          calibrating;
    logic [1:0]  cal_ch;
    int unsigned cal_pt;
    cdac_rsp_t   expected_cmds [$];
    cdac_rsp_t   batch [$];
    int unsigned requests, results, finishes, dropped, mismatches;

    function new();
      foreach (cal_tbl[i]) cal_tbl[i] = '0;
      calibrating = 0;
      cal_ch = '0;
      cal_pt = 0;
    endfunction

    function void add_write(int unsigned ch, int unsigned code);
      cdac_rsp_t w;
      if (ch >= NCH || code >= 4096) begin
        dropped++;
        return;
      end
      w.kind        = KIND_WRITE;
      w.chip_select = 1'((ch >> 1) & 1);
      w.dac_word    = 16'h1000 | 16'(code & 12'hFFF);
      if (ch & 1) w.dac_word = w.dac_word | 16'h8000;
      w.last        = 1'b0;
      batch.push_back(w);
    endfunction

    function void open_point();
      cal_tbl[cal_ch*NPTS + cal_pt] = '0;
      add_write((cal_ch == 2'd3) ? 0 : 3, 500 * cal_pt);
      add_write(cal_ch, 0);
    endfunction

    function void note_request(cdac_req_t r);
      int unsigned base, seg, k;
      int          diff, q;
      logic [15:0] val, stepv;
      cdac_rsp_t   w;
      requests++;
      batch.delete();
      case (r.action)
        ACT_START: begin
          if (r.channel < NCH) begin
            for (int i = 0; i < NCH; i++) add_write(i, 0);
            calibrating = 1;
            cal_ch = r.channel;
            cal_pt = 0;
            open_point();
          end
        end
        ACT_SAMPLE: begin
          if (calibrating) begin
            base = cal_ch * NPTS;
            if (!r.comparator_high) begin
              val = cal_tbl[base + cal_pt] + 16'd1;
              cal_tbl[base + cal_pt] = val;
              add_write(cal_ch, val);
            end else if (cal_pt + 1 < MEAS) begin
              cal_pt++;
              open_point();
            end else begin
              val = cal_tbl[base + MEAS - 1] - cal_tbl[base];
              stepv = val >> 3;
              for (int i = MEAS; i < NPTS; i++)
                cal_tbl[base + i] = cal_tbl[base + i - 1] + stepv;
              calibrating = 0;
              cal_pt = 0;
              w.kind = KIND_DONE;
              w.chip_select = 1'b0;
              w.dac_word = '0;
              w.last = 1'b0;
              batch.push_back(w);
              finishes++;
            end
          end
        end
        ACT_NOTE: begin
          if (r.channel < NCH && r.note <= 83) begin
            seg = r.note / 6;
            k = r.note % 6;
            if (seg + 1 < NPTS) begin
              base = r.channel * NPTS;
              diff = int'(cal_tbl[base + seg + 1]) - int'(cal_tbl[base + seg]);
              q = diff / 6;
              stepv = q[15:0];
              val = cal_tbl[base + seg] + stepv * 16'(k);
              add_write(r.channel, val);
            end
          end
        end
        default: ;
      endcase
      if (batch.size() > 0) begin
        w = batch.pop_back();
        w.last = 1'b1;
        batch.push_back(w);
      end
      foreach (batch[i]) expected_cmds.push_back(batch[i]);
    endfunction

    function void flag(string what, cdac_rsp_t exp, cdac_rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: exp kind=%0d cs=%0d word=%h last=%0d, got kind=%0d cs=%0d word=%h last=%0d",
                 $realtime, what, exp.kind, exp.chip_select, exp.dac_word, exp.last,
                 got.kind, got.chip_select, got.dac_word, got.last);
    endfunction

    function void check_result(cdac_rsp_t got);
      cdac_rsp_t exp;
      results++;
      if (expected_cmds.size() == 0) begin
        exp = '0;
        flag("unexpected result", exp, got);
        return;
      end
      exp = expected_cmds.pop_front();
      if (got.kind !== exp.kind || got.chip_select !== exp.chip_select ||
          got.dac_word !== exp.dac_word || got.last !== exp.last)
        flag("mismatch", exp, got);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cdac_stream_if #(.payload_t(cdac_req_t)) req_if ();
  cdac_stream_if #(.payload_t(cdac_rsp_t)) rsp_if ();

  cv_dac_calibrate_and_note #(
    .NUM_CHANNELS(NCH),
    .TABLE_POINTS(NPTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  dac_cmd_scoreboard sb = new();

  int  stim_items;
  int  send_calm;
  int  recv_calm;
  bit  hold_armed;
  bit  hold_done;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
    end
  end

  // random idle gap drawn per item, with occasional stretches of none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = 20;
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic cdac_req_t req_of(logic [1:0] act, logic [1:0] ch, logic [6:0] nt,
                                       logic hi);
    cdac_req_t r;
    r.action = act;
    r.channel = ch;
    r.note = nt;
    r.comparator_high = hi;
    return r;
  endfunction

  task automatic issue(cdac_req_t r);
    int gap;
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic sample(logic hi);
    issue(req_of(ACT_SAMPLE, 2'($urandom), 7'($urandom), hi));
  endtask

  task automatic start_cal(logic [1:0] ch);
    issue(req_of(ACT_START, ch, 7'($urandom), 1'($urandom)));
  endtask

  task automatic play(logic [1:0] ch, logic [6:0] nt);
    issue(req_of(ACT_NOTE, ch, nt, 1'($urandom)));
  endtask

  task automatic noise();
    issue(req_of(2'($urandom), 2'($urandom), 7'($urandom), 1'($urandom)));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic calibrate_channel(logic [1:0] ch);
    int nlow;
    start_cal(ch);
    stim_items++;
    for (int pt = 0; pt < MEAS; pt++) begin
      nlow = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 5);
      repeat (nlow) begin
        sample(1'b0);
        stim_items++;
      end
      if ($urandom_range(0, 14) == 0) begin
        play(2'($urandom), 7'($urandom_range(0, 83)));
        stim_items++;
      end
      if ($urandom_range(0, 24) == 0) noise();
      if ($urandom_range(0, 39) == 0) return;
      sample(1'b1);
      stim_items++;
    end
    repeat ($urandom_range(2, 6)) begin
      play(ch, ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 83)));
      stim_items++;
    end
  endtask

  // receiver: per-result stalls, one long hold-off once the random phase runs
  initial begin
    int n;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_armed && !hold_done) begin
        n = 300;
        hold_done = 1;
      end else begin
        n = draw_gap(recv_calm);
      end
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  initial begin
    bit paused;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle cases, ignored requests, restart, wrapped extrapolation
    play(2'd0, 7'd0);
    sample(1'b0);
    issue(req_of(ACT_UNUSED, 2'd3, 7'd127, 1'b1));
    play(2'd0, 7'd84);
    play(2'd2, 7'd127);
    start_cal(2'd3);
    sample(1'b0);
    start_cal(2'd1);
    repeat (5) sample(1'b0);
    repeat (MEAS) sample(1'b1);
    play(2'd1, 7'd1);
    play(2'd1, 7'd50);
    play(2'd1, 7'd83);
    wait_drained();

    // ramp on the first point, then notes across the table
    start_cal(2'd2);
    repeat (20) sample(1'b0);
    repeat (MEAS) sample(1'b1);
    play(2'd2, 7'd0);
    play(2'd2, 7'd1);
    play(2'd2, 7'd5);
    play(2'd2, 7'd48);
    play(2'd2, 7'd53);
    wait_drained();

    hold_armed = 1;
    paused = 0;
    stim_items = 0;
    while (stim_items < 250) begin
      if (!paused && stim_items >= 125) begin
        wait_drained();
        paused = 1;
      end
      if ($urandom_range(0, 9) < 7) begin
        calibrate_channel(2'($urandom));
      end else begin
        noise();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("summary: %0d requests, %0d results checked, %0d calibrations finished",
             sb.requests, sb.results, sb.finishes);
    $display("summary: %0d writes dropped, %0d expectations left, %0d mismatches",
             sb.dropped, sb.expected_cmds.size(), sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.expected_cmds.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
